>>> rtl/wsfp_pkg.sv
// shared types and constants for the wheel status frame parser
`timescale 1ns / 1ps
package wsfp_pkg;

  localparam logic [7:0] FrameMark  = 8'h23;
  localparam logic [7:0] StatusCmd  = 8'h04;
  localparam logic [7:0] DigitZero  = 8'h30;
  localparam logic [7:0] DigitNine  = 8'h39;

  localparam logic [7:0] CompactLimitReset = 8'd16;
  localparam logic [6:0] MaxReplyReset     = 7'd64;

  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW  = 8;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_COMPACT_LIMIT = 8'd0,
    CFG_MAX_REPLY     = 8'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_TIMEOUT = 2'd1,
    MODE_START   = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OUT_PENDING  = 3'd0,
    OUT_PARSED   = 3'd1,
    OUT_NORESP   = 3'd2,
    OUT_UNPARSED = 3'd3,
    OUT_IGNORED  = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_TIMEOUT,
    KIND_START,
    KIND_NOP
  } kind_e;

  // classified beat handed from front to back
  typedef struct packed {
    kind_e      kind;
    logic       is_mark;
    logic       is_cmd;
    logic [7:0] value;
  } item_t;

endpackage

>>> rtl/wsfp_if.sv
// channel interfaces: input beats, results and configuration writes
`timescale 1ns / 1ps
interface wsfp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface wsfp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] outcome;
  logic [7:0] position;
  logic [7:0] slot_count;
  modport source (output valid, output outcome, output position, output slot_count,
                  input ready);
  modport sink (input valid, input outcome, input position, input slot_count,
                output ready);
endinterface

interface wsfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/wsfp_front.sv
// front end: accepts input beats and classifies them for the back end
`timescale 1ns / 1ps
module wsfp_front (
  wsfp_in_if.sink         in_i,
  input  logic            q_full_i,
  output logic            push_o,
  output wsfp_pkg::item_t item_o
);
  import wsfp_pkg::*;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  always_comb begin
    item_o.is_mark = (in_i.data_byte == FrameMark);
    item_o.is_cmd  = (in_i.data_byte == StatusCmd);
    // ascii digits map to their value, other bytes pass through
    if (in_i.data_byte >= DigitZero && in_i.data_byte <= DigitNine) begin
      item_o.value = in_i.data_byte - DigitZero;
    end else begin
      item_o.value = in_i.data_byte;
    end
    unique case (mode_e'(in_i.mode))
      MODE_BYTE:    item_o.kind = KIND_BYTE;
      MODE_TIMEOUT: item_o.kind = KIND_TIMEOUT;
      MODE_START:   item_o.kind = KIND_START;
      MODE_NOP:     item_o.kind = KIND_NOP;
      default:      item_o.kind = KIND_NOP;
    endcase
  end

endmodule

>>> rtl/wsfp_queue.sv
// small register queue between front and back
`timescale 1ns / 1ps
module wsfp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wsfp_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output wsfp_pkg::item_t item_o
);
  import wsfp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/wsfp_back.sv
// back end: reply state, frame evaluation, config registers and result register
`timescale 1ns / 1ps
module wsfp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  wsfp_pkg::item_t item_i,
  output logic            pop_o,
  wsfp_cfg_if.sink        cfg_i,
  wsfp_out_if.source      out_o
);
  import wsfp_pkg::*;

  logic [7:0] compact_limit_q;
  logic [6:0] max_reply_q;

  logic [6:0] byte_count_q, byte_count_d;
  logic       inside_q, inside_d;
  logic [1:0] plen_q, plen_d;
  logic [7:0] pval_q [3];
  logic       pcmd_q, pcmd_d;
  logic       failed_q, failed_d;
  logic       finished_q, finished_d;
  logic       wr_en;

  logic       out_valid_q;
  outcome_e   outcome_q, outcome_d;
  logic [7:0] position_q, position_d;
  logic [7:0] slots_q, slots_d;

  logic       ok;
  logic [6:0] count_inc;

  assign pop_o            = q_valid_i && (!out_valid_q || out_o.ready);
  assign out_o.valid      = out_valid_q;
  assign out_o.outcome    = outcome_q;
  assign out_o.position   = position_q;
  assign out_o.slot_count = slots_q;
  assign cfg_i.ready      = 1'b1;
  assign count_inc        = byte_count_q + 7'd1;

  always_comb begin
    byte_count_d = byte_count_q;
    inside_d     = inside_q;
    plen_d       = plen_q;
    pcmd_d       = pcmd_q;
    failed_d     = failed_q;
    finished_d   = finished_q;
    wr_en        = 1'b0;
    ok           = 1'b0;
    outcome_d    = OUT_PENDING;
    position_d   = '0;
    slots_d      = '0;
    if (item_i.kind == KIND_START) begin
      byte_count_d = '0;
      inside_d     = 1'b0;
      plen_d       = '0;
      failed_d     = 1'b0;
      finished_d   = 1'b0;
    end else if (finished_q) begin
      outcome_d = OUT_IGNORED;
    end else if (item_i.kind == KIND_TIMEOUT ||
                 (item_i.kind == KIND_BYTE && byte_count_q >= max_reply_q)) begin
      finished_d = 1'b1;
      outcome_d  = (byte_count_q == '0) ? OUT_NORESP : OUT_UNPARSED;
    end else if (item_i.kind == KIND_BYTE) begin
      byte_count_d = count_inc;
      if (item_i.is_mark) begin
        if (inside_q) begin
          inside_d = 1'b0;
          // frame close: status frame first, then compact form
          if (!failed_q) begin
            if (plen_q >= 2'd2 && pcmd_q) begin
              if (pval_q[1] == '0) begin
                failed_d = 1'b1;
              end else begin
                ok         = 1'b1;
                position_d = pval_q[1];
                slots_d    = (plen_q == 2'd3) ? pval_q[2] : '0;
              end
            end else if (plen_q == 2'd1 && pval_q[0] != '0 &&
                         pval_q[0] <= compact_limit_q) begin
              ok         = 1'b1;
              position_d = pval_q[0];
            end
          end
        end else begin
          inside_d = 1'b1;
          plen_d   = '0;
        end
      end else if (inside_q && plen_q != 2'd3) begin
        wr_en  = 1'b1;
        plen_d = plen_q + 2'd1;
        if (plen_q == '0) begin
          pcmd_d = item_i.is_cmd;
        end
      end
      if (ok) begin
        finished_d = 1'b1;
        outcome_d  = OUT_PARSED;
      end else begin
        position_d = '0;
        slots_d    = '0;
        if (count_inc >= max_reply_q) begin
          finished_d = 1'b1;
          outcome_d  = OUT_UNPARSED;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compact_limit_q <= CompactLimitReset;
      max_reply_q     <= MaxReplyReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_COMPACT_LIMIT: compact_limit_q <= cfg_i.data;
        CFG_MAX_REPLY:     max_reply_q     <= cfg_i.data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      inside_q     <= 1'b0;
      plen_q       <= '0;
      pcmd_q       <= 1'b0;
      failed_q     <= 1'b0;
      finished_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        byte_count_q <= byte_count_d;
        inside_q     <= inside_d;
        plen_q       <= plen_d;
        pcmd_q       <= pcmd_d;
        failed_q     <= failed_d;
        finished_q   <= finished_d;
        out_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      outcome_q  <= outcome_d;
      position_q <= position_d;
      slots_q    <= slots_d;
      if (wr_en) begin
        pval_q[plen_q] <= item_i.value;
      end
    end
  end

  a_start_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.kind == KIND_START |=>
      !finished_q && byte_count_q == '0 && !failed_q && outcome_q == OUT_PENDING)
    else $error("start beat did not clear reply state");

  a_finished_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q && !(pop_o && item_i.kind == KIND_START) |=> finished_q)
    else $error("finished cleared without a start beat");

  a_ignored_after_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && finished_q && item_i.kind != KIND_START |=>
      outcome_q == OUT_IGNORED && byte_count_q == $past(byte_count_q))
    else $error("beat after finish changed state or was not ignored");

  a_parsed_position : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && outcome_q == OUT_PARSED |-> position_q != '0 && finished_q)
    else $error("parsed result with zero position or open reply");

endmodule

>>> rtl/wheel_status_frame_parser.sv
// top level of the wheel status frame parser
//
//  channel | dir | fields                            | beat taken when
//  in_i    | in  | mode, data_byte                   | valid && ready
//  out_o   | out | outcome, position, slot_count     | valid && ready
//  cfg_i   | in  | index, data                       | valid && ready (ready always high)
//
// one beat per cycle sustained while out_o.ready stays high; each beat gives one result, registered
// first as a queue entry, then by the back-end state update into the result register
// the queue of QUEUE_DEPTH entries absorbs result stalls before in_i.ready drops
// reset clears reply state and sets the limits to 16 and 64; no clearing pass
`timescale 1ns / 1ps
module wheel_status_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsfp_in_if.sink     in_i,
  wsfp_cfg_if.sink    cfg_i,
  wsfp_out_if.source  out_o
);
  import wsfp_pkg::*;

  logic  push, q_full, q_valid, pop;
  item_t front_item, head_item;

  wsfp_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (front_item)
  );

  wsfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (head_item)
  );

  wsfp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .item_i    (head_item),
    .pop_o     (pop),
    .cfg_i     (cfg_i),
    .out_o     (out_o)
  );

endmodule
